>>> src/lcps_pkg.sv
package lcps_pkg;

   localparam int LED_COUNT = 8;
   localparam int POS_W     = $clog2(LED_COUNT);
   localparam int MODE_W    = 3;
   localparam int COUNT_W   = 4;

   // Command codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_FILL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FLOWER = 3'd5;

   localparam logic STYLE_MOVE  = 1'b0;
   localparam logic STYLE_BLINK = 1'b1;

   localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
   localparam logic [POS_W-1:0] POS_LAST  = 3'd7;
   localparam logic [POS_W-1:0] POS_INNER = 3'd3;
   localparam logic [POS_W-1:0] POS_OUTER = 3'd5;
   localparam logic [POS_W-1:0] POS_TURN  = 3'd6;

   typedef struct packed {
      logic [LED_COUNT-1:0] levels;
      logic [POS_W-1:0]     position;
      logic                 phase;
   } lcps_state_type;

   // Single LED bit for an index.
   function automatic logic [LED_COUNT-1:0] led_bit(input logic [POS_W-1:0] idx);
      led_bit = {{(LED_COUNT-1){1'b0}}, 1'b1} << idx;
   endfunction

   // Mask of the lowest count LEDs, count saturated at the LED count.
   function automatic logic [LED_COUNT-1:0] fill_mask(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] fill;
      logic [LED_COUNT:0] wide;
      fill = (count > COUNT_W'(LED_COUNT)) ? COUNT_W'(LED_COUNT) : count;
      wide = ({{LED_COUNT{1'b0}}, 1'b1} << fill) - {{LED_COUNT{1'b0}}, 1'b1};
      fill_mask = wide[LED_COUNT-1:0];
   endfunction

endpackage

>>> src/lcps_if.sv
interface lcps_req_if;
   logic                        valid;
   logic                        ready;
   logic [lcps_pkg::MODE_W-1:0]  mode;
   logic [lcps_pkg::COUNT_W-1:0] count;
   logic                        style;

   modport source (output valid, output mode, output count, output style, input ready);
   modport sink   (input valid, input mode, input count, input style, output ready);
endinterface

interface lcps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lcps_pkg::LED_COUNT-1:0] leds;

   modport source (output valid, output leds, input ready);
   modport sink   (input valid, input leds, output ready);
endinterface

>>> src/lcps_step.sv
module lcps_step (
   input  lcps_pkg::lcps_state_type        cur,
   input  logic [lcps_pkg::MODE_W-1:0]     mode,
   input  logic [lcps_pkg::COUNT_W-1:0]    count,
   input  logic                            style,
   output lcps_pkg::lcps_state_type        nxt
);

   logic [lcps_pkg::COUNT_W-1:0]   span;
   logic [lcps_pkg::POS_W-1:0]     span_last;
   logic [lcps_pkg::POS_W-1:0]     right_edge;
   logic [lcps_pkg::POS_W-1:0]     p;
   logic [lcps_pkg::POS_W-1:0]     mirror;
   logic [lcps_pkg::POS_W-1:0]     flower_next;
   logic [lcps_pkg::POS_W-1:0]     left_next;
   logic [lcps_pkg::POS_W-1:0]     right_next;
   logic [lcps_pkg::LED_COUNT-1:0] lit_mask;
   logic [lcps_pkg::LED_COUNT-1:0] dark_mask;
   logic [lcps_pkg::LED_COUNT-1:0] fmask;

   always_comb begin
      p      = cur.position;
      mirror = lcps_pkg::POS_LAST - p;
      fmask  = lcps_pkg::fill_mask(count);

      if (count == '0) begin
         span = {{(lcps_pkg::COUNT_W-1){1'b0}}, 1'b1};
      end else if (count > lcps_pkg::COUNT_W'(lcps_pkg::LED_COUNT)) begin
         span = lcps_pkg::COUNT_W'(lcps_pkg::LED_COUNT);
      end else begin
         span = count;
      end
      span_last  = lcps_pkg::POS_W'(span - {{(lcps_pkg::COUNT_W-1){1'b0}}, 1'b1});
      right_edge = lcps_pkg::POS_W'(lcps_pkg::COUNT_W'(lcps_pkg::LED_COUNT) - span);

      left_next  = (p >= span_last) ? lcps_pkg::POS_FIRST : p + 1'b1;
      right_next = (p <= right_edge) ? lcps_pkg::POS_LAST : p - 1'b1;

      // The flower skips from the inner pair straight to the outgoing half.
      if (p == lcps_pkg::POS_INNER) begin
         flower_next = lcps_pkg::POS_OUTER;
      end else if (p >= lcps_pkg::POS_TURN) begin
         flower_next = lcps_pkg::POS_FIRST;
      end else begin
         flower_next = p + 1'b1;
      end

      lit_mask  = '0;
      dark_mask = '0;
      nxt       = cur;

      case (mode)
         lcps_pkg::MODE_FILL: begin
            lit_mask = fmask;
         end
         lcps_pkg::MODE_CLEAR: begin
            dark_mask = fmask;
         end
         lcps_pkg::MODE_TOGGLE: begin
            // Toggling is handled outside the lit/dark masks.
         end
         lcps_pkg::MODE_LEFT: begin
            if (style == lcps_pkg::STYLE_MOVE) begin
               lit_mask     = lcps_pkg::led_bit(p);
               dark_mask    = lcps_pkg::led_bit((p == lcps_pkg::POS_FIRST) ? span_last
                                                                            : p - 1'b1);
               nxt.position = left_next;
            end else if (!cur.phase) begin
               lit_mask  = lcps_pkg::led_bit((p >= span_last) ? span_last : p);
               nxt.phase = 1'b1;
            end else begin
               dark_mask    = lcps_pkg::led_bit((p >= span_last) ? span_last : p);
               nxt.phase    = 1'b0;
               nxt.position = left_next;
            end
         end
         lcps_pkg::MODE_RIGHT: begin
            if (style == lcps_pkg::STYLE_MOVE) begin
               if (p == lcps_pkg::POS_LAST) begin
                  lit_mask  = lcps_pkg::led_bit(lcps_pkg::POS_LAST);
                  dark_mask = lcps_pkg::led_bit(right_edge);
               end else begin
                  lit_mask  = lcps_pkg::led_bit(p);
                  dark_mask = lcps_pkg::led_bit(p + 1'b1);
               end
               nxt.position = right_next;
            end else if (!cur.phase) begin
               lit_mask  = lcps_pkg::led_bit((p <= right_edge) ? right_edge : p);
               nxt.phase = 1'b1;
            end else begin
               dark_mask    = lcps_pkg::led_bit((p <= right_edge) ? right_edge : p);
               nxt.phase    = 1'b0;
               nxt.position = right_next;
            end
         end
         lcps_pkg::MODE_FLOWER: begin
            if (style == lcps_pkg::STYLE_MOVE) begin
               // The dark pair trails the lit pair; at the start it sits just inside.
               lit_mask     = lcps_pkg::led_bit(p) | lcps_pkg::led_bit(mirror);
               dark_mask    = (p == lcps_pkg::POS_FIRST)
                            ? (lcps_pkg::led_bit(p + 1'b1) | lcps_pkg::led_bit(mirror - 1'b1))
                            : (lcps_pkg::led_bit(p - 1'b1) | lcps_pkg::led_bit(mirror + 1'b1));
               nxt.position = (p == lcps_pkg::POS_FIRST) ? p + 1'b1 : flower_next;
            end else if (!cur.phase) begin
               lit_mask  = lcps_pkg::led_bit(p) | lcps_pkg::led_bit(mirror);
               nxt.phase = 1'b1;
            end else begin
               dark_mask    = lcps_pkg::led_bit(p) | lcps_pkg::led_bit(mirror);
               nxt.phase    = 1'b0;
               nxt.position = flower_next;
            end
         end
         default: begin
         end
      endcase

      // Light first, then darken, so an LED named by both ends dark.
      if (mode == lcps_pkg::MODE_TOGGLE) begin
         nxt.levels = cur.levels ^ fmask;
      end else begin
         nxt.levels = (cur.levels | lit_mask) & ~dark_mask;
      end
   end

endmodule

>>> src/led_chaser_pattern_sequencer.sv
// LED chaser pattern sequencer.
//
// Commands arrive on the req channel (mode, count, style); every command
// produces exactly one transfer on the rsp channel carrying the eight LED
// levels as they stand after that command. Both channels use valid/ready and
// a transfer happens on a rising clock edge with valid and ready both high.
//
// A command taken on a rising edge is held in the command register; once the
// result register is free, its update is applied to the pattern state and
// the result register together, and rsp valid is driven by the result
// register. Throughput is one command per cycle while the receiver takes
// every result; each command performs a single update of the state register.
//
// When the receiver stalls, the result stays in the result register and one
// more command may wait in the command register; req ready then drops until
// the result is taken. Reset (synchronous, active high) darkens all LEDs,
// returns the shared position to zero, clears the blink phase and empties
// both registers.
module led_chaser_pattern_sequencer (
   input  logic       clock,
   input  logic       reset,
   lcps_req_if.sink   req_ch,
   lcps_rsp_if.source rsp_ch
);

   // Command register, loaded whenever it is empty or about to drain.
   logic                         cmd_valid_ff;
   logic [lcps_pkg::MODE_W-1:0]  cmd_mode_ff;
   logic [lcps_pkg::COUNT_W-1:0] cmd_count_ff;
   logic                         cmd_style_ff;

   // Pattern state shared by all commands and the result register.
   lcps_pkg::lcps_state_type       state_ff;
   lcps_pkg::lcps_state_type       state_in;
   logic                           res_valid_ff;
   logic [lcps_pkg::LED_COUNT-1:0] res_leds_ff;

   logic res_free;
   logic advance;

   // The result register can take a new value when it is empty or its
   // current transfer completes in this cycle.
   assign res_free = !res_valid_ff || rsp_ch.ready;
   assign advance  = cmd_valid_ff && res_free;

   assign req_ch.ready = !cmd_valid_ff || res_free;
   assign rsp_ch.valid = res_valid_ff;
   assign rsp_ch.leds  = res_leds_ff;

   lcps_step u_step (
      .cur   (state_ff),
      .mode  (cmd_mode_ff),
      .count (cmd_count_ff),
      .style (cmd_style_ff),
      .nxt   (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         cmd_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         cmd_mode_ff  <= req_ch.mode;
         cmd_count_ff <= req_ch.count;
         cmd_style_ff <= req_ch.style;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         state_ff     <= state_in;
         res_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_leds_ff <= state_in.levels;
      end
   end

endmodule
